// ----- hdl/sle_pkg.sv -----
`default_nettype none

package sle_pkg;

	localparam int FUNC_W = 2;
	localparam int POS_W  = 9;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]  pos_t;

	localparam func_t FUNC_INSERT  = 2'd0;
	localparam func_t FUNC_DELETE  = 2'd1;
	localparam func_t FUNC_ORDERED = 2'd2;
	localparam func_t FUNC_READ    = 2'd3;

	localparam status_t STAT_OK     = 2'd0;
	localparam status_t STAT_BADPOS = 2'd1;
	localparam status_t STAT_FULL   = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/sle_req_if.sv -----
`default_nettype none

interface sle_req_if
	import sle_pkg::*;
	;
	logic         valid;
	logic         ready;
	func_t        func;
	pos_t         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

// ----- hdl/sle_rsp_if.sv -----
`default_nettype none

interface sle_rsp_if
	import sle_pkg::*;
	;
	logic         valid;
	logic         ready;
	status_t      status;
	logic signed [DATA_W-1:0] result_value;
	pos_t         placed_at;
	pos_t         list_count;

	modport source (output valid, output status, output result_value, output placed_at,
		output list_count, input ready);
	modport sink (input valid, input status, input result_value, input placed_at,
		input list_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/sle_mem.sv -----
`default_nettype none

module sle_mem
	import sle_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output data_t              rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire data_t         wr_data
);

	data_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; the write port never targets the entry read in the same cycle.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sequential_list_engine_unit.sv -----
// A rejected request goes straight to the finish state and a read through the read-wait state;
// a delete walks from the position to the end, an insert walks the same span and an ordered insert
// the whole list; both then place at the tail. Per cycle a walk does at most one read and one write.
// One request is in work at a time; the next is taken in the cycle after the response register
// loads, even while that response still waits. Reset clears the count and the control logic;
// the element memory is not cleared, since only entries below the count are ever read.
`default_nettype none

module sequential_list_engine_unit
	import sle_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sle_req_if.sink    req,
	sle_rsp_if.source  rsp
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNTW = $clog2(CAPACITY + 1);
	localparam int XW   = (CNTW > POS_W) ? CNTW : POS_W;
	localparam int EW   = XW + 1;

	// Controller states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_DEL   = 3'd2;
	localparam logic [2:0] ST_RDW   = 3'd3;
	localparam logic [2:0] ST_TAIL  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]      state_q;
	logic [CNTW-1:0] count_q;
	logic [AW-1:0]   cur_q;
	logic            first_q;
	logic            found_q;
	data_t           carry_q;
	data_t           val_q;
	status_t         status_q;
	data_t           rv_q;
	logic [CNTW-1:0] placed_q;

	logic    rsp_valid_q;
	status_t rsp_status_q;
	data_t   rsp_value_q;
	pos_t    rsp_placed_q;
	pos_t    rsp_count_q;

	// Memory port signals.
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	data_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	data_t         wr_data;

	// Request decode against the current count.
	logic [EW-1:0]   pos_x;
	logic [EW-1:0]   cnt_x;
	logic [EW-1:0]   pos_m1;
	logic [AW-1:0]   start_a;
	logic            pos_ok_ins;
	logic            pos_ok_rd;
	logic            full;
	logic            req_xfer;
	logic            rsp_load;

	// Walk control.
	logic [AW-1:0]   next_a;
	logic            more;
	logic            data_gt;
	logic            shift_wr;

	logic [XW-1:0]   placed_x;
	logic [XW-1:0]   count_ox;

	assign pos_x      = EW'(req.position);
	assign cnt_x      = EW'(count_q);
	assign pos_m1     = pos_x - EW'(1);
	assign start_a    = pos_m1[AW-1:0];
	assign pos_ok_ins = (pos_x != '0) && (pos_x <= cnt_x + EW'(1));
	assign pos_ok_rd  = (pos_x != '0) && (pos_x <= cnt_x);
	assign full       = (count_q == CNTW'(CAPACITY));

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;

	// The finished response loads when the output register is empty or drains this cycle.
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	assign next_a   = cur_q + AW'(1);
	assign more     = (CNTW'(cur_q) + CNTW'(1)) < count_q;
	assign data_gt  = $signed(rd_data) > $signed(val_q);
	// Ordered insert writes nothing until it meets the first larger entry; insert writes from the start.
	assign shift_wr = found_q || data_gt;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = start_a;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = carry_q;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					case (req.func)
						FUNC_INSERT: begin
							rd_en = pos_ok_ins && !full && (pos_m1 != cnt_x);
						end
						FUNC_ORDERED: begin
							rd_en   = !full && (count_q != '0);
							rd_addr = '0;
						end
						default: begin
							rd_en = pos_ok_rd;
						end
					endcase
				end
			end
			ST_SHIFT: begin
				// Each entry at or beyond the insert point takes the carried value and hands its own on.
				wr_en   = shift_wr;
				rd_en   = more;
				rd_addr = next_a;
			end
			ST_DEL: begin
				// After the removed entry, every later entry moves one place toward the front.
				wr_en   = !first_q;
				wr_addr = cur_q - AW'(1);
				wr_data = rd_data;
				rd_en   = more;
				rd_addr = next_a;
			end
			ST_TAIL: begin
				wr_en   = 1'b1;
				wr_addr = count_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	sle_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			found_q     <= 1'b0;
			first_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						first_q <= 1'b1;
						case (req.func)
							FUNC_INSERT: begin
								found_q <= 1'b1;
								if (!pos_ok_ins || full) begin
									state_q <= ST_FIN;
								end else if (pos_m1 == cnt_x) begin
									state_q <= ST_TAIL;
								end else begin
									state_q <= ST_SHIFT;
								end
							end
							FUNC_DELETE: begin
								state_q <= pos_ok_rd ? ST_DEL : ST_FIN;
							end
							FUNC_ORDERED: begin
								found_q <= 1'b0;
								if (full) begin
									state_q <= ST_FIN;
								end else if (count_q == '0) begin
									state_q <= ST_TAIL;
								end else begin
									state_q <= ST_SHIFT;
								end
							end
							default: begin
								state_q <= pos_ok_rd ? ST_RDW : ST_FIN;
							end
						endcase
					end
				end
				ST_SHIFT: begin
					if (shift_wr) begin
						found_q <= 1'b1;
					end
					if (!more) begin
						state_q <= ST_TAIL;
					end
				end
				ST_DEL: begin
					first_q <= 1'b0;
					if (!more) begin
						count_q <= count_q - CNTW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_RDW: begin
					state_q <= ST_FIN;
				end
				ST_TAIL: begin
					count_q <= count_q + CNTW'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Working payload: carried value, walk pointer and the pieces of the response.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					carry_q  <= req.value;
					val_q    <= req.value;
					rv_q     <= '0;
					placed_q <= '0;
					status_q <= STAT_OK;
					cur_q    <= start_a;
					case (req.func)
						FUNC_INSERT: begin
							if (!pos_ok_ins) begin
								status_q <= STAT_BADPOS;
							end else if (full) begin
								status_q <= STAT_FULL;
							end else begin
								placed_q <= pos_x[CNTW-1:0];
							end
						end
						FUNC_ORDERED: begin
							cur_q <= '0;
							if (full) begin
								status_q <= STAT_FULL;
							end
						end
						default: begin
							if (!pos_ok_rd) begin
								status_q <= STAT_BADPOS;
							end
						end
					endcase
				end
			end
			ST_SHIFT: begin
				if (shift_wr) begin
					carry_q <= rd_data;
					if (!found_q) begin
						placed_q <= CNTW'(cur_q) + CNTW'(1);
					end
				end
				if (more) begin
					cur_q <= next_a;
				end
			end
			ST_DEL: begin
				if (first_q) begin
					rv_q <= rd_data;
				end
				if (more) begin
					cur_q <= next_a;
				end
			end
			ST_RDW: begin
				rv_q <= rd_data;
			end
			ST_TAIL: begin
				// An ordered insert that met no larger entry lands at the end.
				if (!found_q) begin
					placed_q <= count_q + CNTW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign placed_x = XW'(placed_q);
	assign count_ox = XW'(count_q);

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_value_q  <= rv_q;
			rsp_placed_q <= placed_x[POS_W-1:0];
			rsp_count_q  <= count_ox[POS_W-1:0];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.result_value = rsp_value_q;
	assign rsp.placed_at    = rsp_placed_q;
	assign rsp.list_count   = rsp_count_q;

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(CAPACITY))
		else $error("element count above capacity");

	// The memory is written only while a shift or the final placement is in progress.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SHIFT || state_q == ST_DEL || state_q == ST_TAIL))
		else $error("memory write outside a walk");

	// The final placement adds exactly one entry.
	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |=> (count_q == $past(count_q) + CNTW'(1)))
		else $error("tail placement did not grow the count by one");

	// A full store never starts a placement.
	a_full_no_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAIL) |-> !full)
		else $error("placement into a full store");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps

// This bench checks the ordered list engine from its two channels. A
// request transfer carries an operation, a 1-based position and a signed
// value. Each response transfer carries a status, a returned value, the
// position an insert landed at, and the count after the request.
//
// The bench keeps a shadow copy of the list and of its count. When a
// request is accepted, the shadow list works out the response the engine
// owes and files it at the back of a queue. Each response transfer is
// compared field by field with the oldest filed response. A response with
// nothing filed, a field that differs, and a filed response still waiting
// at the end all count as failures. The run always goes on to its end.
//
// The stimulus runs in the following phases:
//   - a short directed script covering the empty list, bad positions,
//     value extremes and ties in the ordered insert;
//   - a random mix with no idling on either side;
//   - the same mix with the sender idle most of the time;
//   - the list filled to capacity by ordered inserts, the full-store cases
//     probed, then the list emptied by deletes, with the receiver stalling
//     most of the time;
//   - the random mix again with light idling on both sides.

module tb
	import sle_pkg::*;
	;

	localparam int LIST_DEPTH = 256;
	// The tail wait covers the slowest request, which walks the whole list.
	localparam int TAIL_CYCLES = LIST_DEPTH + 40;
	localparam int MIX_ITEMS = 430;

	localparam data_t WORD_MAX  = 32'h7FFF_FFFF;
	localparam data_t WORD_MIN  = 32'h8000_0000;
	localparam data_t WORD_ONES = 32'hFFFF_FFFF;

	typedef struct packed {
		status_t status;
		data_t   result_value;
		pos_t    placed_at;
		pos_t    list_count;
	} outcome_t;

	// One row of the directed script. When fixed is set, the outcome given
	// in the row is the response expected. Otherwise the shadow list
	// supplies the expected response.
	typedef struct packed {
		func_t    func;
		pos_t     position;
		data_t    value;
		logic     fixed;
		outcome_t outcome;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sle_req_if req_ch ();
	sle_rsp_if rsp_ch ();

	sequential_list_engine_unit #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the engine's list and count.
	logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
	int shadow_count = 0;

	// Responses owed by the engine, oldest first.
	outcome_t pending_outcomes [$];
	int mismatch_count = 0;

	// Percent chance, per cycle, that the sender holds back or that the
	// receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// The directed script starts from an empty list. Rows with a fixed
	// outcome can be worked out by hand. The last few rows come after the
	// list has been reshuffled, so the shadow list supplies their responses.
	script_row_t opening_script [25] = '{
		// Requests on the empty list after reset.
		'{FUNC_READ,    9'd1,   32'd0,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd0}},
		'{FUNC_DELETE,  9'd1,   32'd0,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd0}},
		'{FUNC_INSERT,  9'd0,   32'd5,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd0}},
		'{FUNC_INSERT,  9'd2,   32'd5,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd0}},
		'{FUNC_INSERT,  9'd511, WORD_ONES, 1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd0}},
		// Build the list [MIN, 0, 0, MAX, MAX, -1].
		'{FUNC_INSERT,  9'd1,   WORD_MAX,  1'b1, '{STAT_OK, 32'd0, 9'd1, 9'd1}},
		'{FUNC_ORDERED, 9'd0,   WORD_MIN,  1'b1, '{STAT_OK, 32'd0, 9'd1, 9'd2}},
		'{FUNC_ORDERED, 9'd0,   32'd0,     1'b1, '{STAT_OK, 32'd0, 9'd2, 9'd3}},
		// An equal value goes after the entry it ties with.
		'{FUNC_ORDERED, 9'd0,   WORD_MAX,  1'b1, '{STAT_OK, 32'd0, 9'd4, 9'd4}},
		'{FUNC_ORDERED, 9'd0,   32'd0,     1'b1, '{STAT_OK, 32'd0, 9'd3, 9'd5}},
		'{FUNC_INSERT,  9'd6,   WORD_ONES, 1'b1, '{STAT_OK, 32'd0, 9'd6, 9'd6}},
		'{FUNC_INSERT,  9'd8,   32'd1,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd6}},
		// Read at both ends of the list and one past each end.
		'{FUNC_READ,    9'd1,   32'd0,     1'b1, '{STAT_OK, WORD_MIN, 9'd0, 9'd6}},
		'{FUNC_READ,    9'd6,   32'd0,     1'b1, '{STAT_OK, WORD_ONES, 9'd0, 9'd6}},
		'{FUNC_READ,    9'd7,   32'd0,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd6}},
		'{FUNC_READ,    9'd0,   32'd0,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd6}},
		'{FUNC_DELETE,  9'd0,   32'd0,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd6}},
		'{FUNC_DELETE,  9'd7,   32'd0,     1'b1, '{STAT_BADPOS, 32'd0, 9'd0, 9'd6}},
		'{FUNC_DELETE,  9'd1,   32'd0,     1'b1, '{STAT_OK, WORD_MIN, 9'd0, 9'd5}},
		'{FUNC_DELETE,  9'd5,   32'd0,     1'b1, '{STAT_OK, WORD_ONES, 9'd0, 9'd4}},
		'{FUNC_ORDERED, 9'd0,   WORD_ONES, 1'b0, '0},
		'{FUNC_INSERT,  9'd3,   32'h5555_5555, 1'b0, '0},
		'{FUNC_DELETE,  9'd2,   32'd0,     1'b0, '0},
		'{FUNC_READ,    9'd3,   32'd0,     1'b0, '0},
		'{FUNC_INSERT,  9'd1,   32'hAAAA_AAAA, 1'b0, '0}
	};

	// Open a gap at 0-based slot and put the value there. The caller has
	// already checked that the list has room.
	function automatic void shadow_place(int slot, data_t value);
		int k;
		for (k = shadow_count; k > slot; k--)
			shadow_list[k] = shadow_list[k - 1];
		shadow_list[slot] = value;
		shadow_count++;
	endfunction

	// Apply one accepted request to the shadow list and return the response
	// the engine owes for it.
	function automatic outcome_t apply_list_request(func_t func, pos_t position, data_t value);
		outcome_t owed;
		int p;
		int k;
		owed = '0;
		owed.status = STAT_OK;
		p = position;
		case (func)
			FUNC_INSERT: begin
				// The position is checked before the full-store test.
				if (p < 1 || p > shadow_count + 1) begin
					owed.status = STAT_BADPOS;
				end else if (shadow_count >= LIST_DEPTH) begin
					owed.status = STAT_FULL;
				end else begin
					shadow_place(p - 1, value);
					owed.placed_at = pos_t'(p);
				end
			end
			FUNC_DELETE: begin
				if (p < 1 || p > shadow_count) begin
					owed.status = STAT_BADPOS;
				end else begin
					owed.result_value = shadow_list[p - 1];
					for (k = p; k < shadow_count; k++)
						shadow_list[k - 1] = shadow_list[k];
					shadow_count--;
				end
			end
			FUNC_ORDERED: begin
				// The value lands before the first entry that is strictly
				// greater, so it goes after any entries it ties with.
				if (shadow_count >= LIST_DEPTH) begin
					owed.status = STAT_FULL;
				end else begin
					k = 0;
					while (k < shadow_count && !($signed(shadow_list[k]) > $signed(value)))
						k++;
					shadow_place(k, value);
					owed.placed_at = pos_t'(k + 1);
				end
			end
			default: begin
				if (p < 1 || p > shadow_count)
					owed.status = STAT_BADPOS;
				else
					owed.result_value = shadow_list[p - 1];
			end
		endcase
		owed.list_count = pos_t'(shadow_count);
		return owed;
	endfunction

	// Offer one request and hold it until the transfer. This task is always
	// entered in the time step of a rising edge. In that step it either
	// lowers valid for an idle cycle or drives the next request, but it
	// never does both. Since req_ch.ready is read right after the edge, the
	// value seen is the one from before the edge, which is the value that
	// decided the transfer.
	task automatic send_request(func_t func, pos_t position, data_t value,
			logic fixed, outcome_t typed);
		outcome_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= func;
		req_ch.position <= position;
		req_ch.value <= value;
		do @(posedge clk); while (!req_ch.ready);
		predicted = apply_list_request(func, position, value);
		pending_outcomes.push_back(fixed ? typed : predicted);
	endtask

	// Hold the request side idle until every owed response has arrived.
	// This always lets at least one edge pass, so valid is never lowered
	// and raised again in the same step.
	task automatic wait_for_outcomes();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_outcomes.size() != 0);
	endtask

	// Values come in three kinds. Small values near zero give plenty of
	// ties for the ordered insert. The extremes come up often. The rest are
	// full 32-bit random values.
	function automatic data_t pick_value();
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 25) begin
			v = int'($urandom_range(16)) - 8;
			return data_t'(v);
		end
		if (r < 35) begin
			case ($urandom_range(3))
				0: return WORD_MIN;
				1: return WORD_MAX;
				2: return '0;
				default: return WORD_ONES;
			endcase
		end
		return data_t'($urandom);
	endfunction

	// Most positions fall inside 1..top. The rest are zero, one past top,
	// or any 9-bit value, so every position bit takes both values.
	function automatic pos_t pick_position(int top);
		int r;
		r = $urandom_range(99);
		if (r < 82 && top >= 1)
			return pos_t'($urandom_range(top, 1));
		if (r < 88)
			return '0;
		if (r < 94)
			return pos_t'(top + 1);
		return pos_t'($urandom_range(511));
	endfunction

	// Random mix of all four operations. The mix tilts toward growing the
	// list while it is short and toward shrinking it once it holds a few
	// dozen entries, so each walk stays a moderate length. Now and then
	// the sender waits until every owed response has arrived.
	task automatic send_random_mix(int items);
		int n;
		int grow_pct;
		int r;
		func_t func;
		pos_t position;
		for (n = 0; n < items; n++) begin
			if ($urandom_range(39) == 0)
				wait_for_outcomes();
			grow_pct = (shadow_count < 8) ? 70 : (shadow_count > 48) ? 25 : 45;
			r = $urandom_range(99);
			if (r < grow_pct / 2) begin
				func = FUNC_INSERT;
				position = pick_position(shadow_count + 1);
			end else if (r < grow_pct) begin
				// The ordered insert ignores the position, so random bits are sent.
				func = FUNC_ORDERED;
				position = pos_t'($urandom_range(511));
			end else if (r < grow_pct + (100 - grow_pct) / 2) begin
				func = FUNC_DELETE;
				position = pick_position(shadow_count);
			end else begin
				func = FUNC_READ;
				position = pick_position(shadow_count);
			end
			send_request(func, position, pick_value(), 1'b0, '0);
		end
	endtask

	// Fill the list to capacity with ordered inserts, then probe the full
	// store. With the list full, a bad position still reports a bad
	// position, while a good one reports a full store. The list is then
	// emptied by deletes at random positions, with a few reads along the
	// way.
	task automatic fill_and_drain();
		while (shadow_count < LIST_DEPTH)
			send_request(FUNC_ORDERED, pos_t'($urandom_range(511)), pick_value(), 1'b0, '0);
		send_request(FUNC_INSERT, 9'd0, 32'd7, 1'b0, '0);
		send_request(FUNC_INSERT, pos_t'(LIST_DEPTH + 2), 32'd7, 1'b0, '0);
		send_request(FUNC_INSERT, pos_t'(LIST_DEPTH + 1), 32'd7, 1'b0, '0);
		send_request(FUNC_INSERT, 9'd1, WORD_MIN, 1'b0, '0);
		send_request(FUNC_ORDERED, 9'd0, WORD_MAX, 1'b0, '0);
		send_request(FUNC_ORDERED, 9'd0, WORD_MIN, 1'b0, '0);
		send_request(FUNC_READ, pos_t'(LIST_DEPTH), 32'd0, 1'b0, '0);
		send_request(FUNC_READ, pos_t'(LIST_DEPTH + 1), 32'd0, 1'b0, '0);
		send_request(FUNC_DELETE, pos_t'(LIST_DEPTH + 1), 32'd0, 1'b0, '0);
		send_request(FUNC_DELETE, pos_t'(LIST_DEPTH), 32'd0, 1'b0, '0);
		// The list now has one free slot, so the last position is valid
		// for an insert.
		send_request(FUNC_INSERT, pos_t'(LIST_DEPTH), WORD_ONES, 1'b0, '0);
		send_request(FUNC_READ, pos_t'(LIST_DEPTH), 32'd0, 1'b0, '0);
		send_request(FUNC_DELETE, 9'd1, 32'd0, 1'b0, '0);
		while (shadow_count > 0) begin
			if ($urandom_range(4) == 0)
				send_request(FUNC_READ, pos_t'($urandom_range(shadow_count, 1)),
					32'd0, 1'b0, '0);
			else
				send_request(FUNC_DELETE, pos_t'($urandom_range(shadow_count, 1)),
					32'd0, 1'b0, '0);
		end
	endtask

	// Compare one response transfer with the oldest owed response.
	task automatic check_outcome();
		outcome_t due;
		if (pending_outcomes.size() == 0) begin
			$error("response transfer with no request outstanding");
			mismatch_count++;
		end else begin
			due = pending_outcomes.pop_front();
			if (rsp_ch.status !== due.status) begin
				$error("status: expected %0d, got %0d", due.status, rsp_ch.status);
				mismatch_count++;
			end
			if (rsp_ch.result_value !== due.result_value) begin
				$error("result_value: expected %0d, got %0d",
					$signed(due.result_value), rsp_ch.result_value);
				mismatch_count++;
			end
			if (rsp_ch.placed_at !== due.placed_at) begin
				$error("placed_at: expected %0d, got %0d", due.placed_at, rsp_ch.placed_at);
				mismatch_count++;
			end
			if (rsp_ch.list_count !== due.list_count) begin
				$error("list_count: expected %0d, got %0d", due.list_count, rsp_ch.list_count);
				mismatch_count++;
			end
		end
	endtask

	// Receiver side. The response is sampled at the rising edge, where the
	// values seen are the ones from before the edge. Ready for the next
	// cycle is then chosen at random according to the stall setting.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_outcome();
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_INSERT;
		req_ch.position = '0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script with no idling on either side.
		foreach (opening_script[i])
			send_request(opening_script[i].func, opening_script[i].position,
				opening_script[i].value, opening_script[i].fixed, opening_script[i].outcome);
		wait_for_outcomes();

		send_random_mix(MIX_ITEMS);
		wait_for_outcomes();

		// Sender idle most of the time, so gaps often land during a walk.
		send_idle_pct = 81;
		send_random_mix(MIX_ITEMS);
		wait_for_outcomes();

		// Receiver stalls most of the time. A response waits while the
		// next request is already taken in.
		send_idle_pct = 0;
		recv_stall_pct = 81;
		fill_and_drain();
		wait_for_outcomes();

		send_idle_pct = 7;
		recv_stall_pct = 7;
		send_random_mix(MIX_ITEMS);
		wait_for_outcomes();

		// Let a late extra response show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog for a hung handshake. A correct run needs well under a tenth
	// of this time.
	initial begin
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/sle_pkg.sv
hdl/sle_req_if.sv
hdl/sle_rsp_if.sv
hdl/sle_mem.sv
hdl/sequential_list_engine_unit.sv
test/tb.sv
